[design/ttb_pkg.sv]
// Types, widths and latency constants shared by the tangent/binormal unit.
package ttb_pkg;

  localparam int unsigned COMP_W     = 16;              // one packed Q-format component
  localparam int unsigned DIFF_W     = COMP_W + 1;      // edge / texture delta
  localparam int unsigned PROD_W     = 2 * DIFF_W;      // product of two deltas
  localparam int unsigned VEC_W      = PROD_W + 1;      // unnormalised component
  localparam int unsigned MAG_W      = VEC_W - 1;       // magnitude, at most 2^33
  localparam int unsigned MSB_W      = $clog2(MAG_W);
  localparam int unsigned NORM_W     = 30;              // normalised magnitude width
  localparam int unsigned SH_W       = $clog2(NORM_W);
  localparam int unsigned SQ_W       = 2 * NORM_W;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned SQRT_STEPS = SUM_W / 2;
  localparam int unsigned ROOT_W     = SQRT_STEPS;
  localparam int unsigned UNIT_SH    = 14;              // Q1.14
  localparam int unsigned Q_W        = UNIT_SH + 1;
  localparam int unsigned DIV_W      = ROOT_W + Q_W;
  localparam int unsigned FRONT_LAT  = 5;
  localparam int unsigned UNIT_LAT   = 4 + 1 + SQRT_STEPS + 1 + Q_W;
  localparam int unsigned PIPE_LAT   = FRONT_LAT + UNIT_LAT + 1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DET_ZERO = 2'd1,
    ST_TAN_ZERO = 2'd2,
    ST_BIN_ZERO = 2'd3
  } status_e;

  typedef struct packed {
    logic [47:0] first_position;
    logic [31:0] first_texcoord;
    logic [47:0] second_position;
    logic [31:0] second_texcoord;
    logic [47:0] third_position;
    logic [31:0] third_texcoord;
  } in_t;

  typedef struct packed {
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
    logic signed [15:0] binormal_x;
    logic signed [15:0] binormal_y;
    logic signed [15:0] binormal_z;
    status_e            status;
  } out_t;

  typedef struct packed {
    logic [2:0] tsign;
    logic [2:0] bsign;
    status_e    status;
  } side_t;

endpackage

[design/ttb_unitize.sv]
// Pipelined vector normaliser: scale, sum of squares, square root, divide.
module ttb_unitize import ttb_pkg::*; (
  input  logic                        clk_i,
  input  logic [2:0][MAG_W-1:0]       mag_i,
  output logic [2:0][Q_W-1:0]         quot_o
);

  logic [2:0][MAG_W-1:0]  m1_q, m2_q;
  logic [MAG_W-1:0]       mx_d, mx_q;
  logic [MSB_W-1:0]       msb_d;
  logic                   lsh_d, lsh_q;
  logic [SH_W-1:0]        amt_d, amt_q;
  logic [2:0][NORM_W-1:0] n_d, n_q, nsq_q;
  logic [2:0][SQ_W-1:0]   sq_q;

  logic [SUM_W-1:0]       rem_q [SQRT_STEPS+1];
  logic [SUM_W-1:0]       res_q [SQRT_STEPS+1];
  logic [2:0][NORM_W-1:0] nn_q  [SQRT_STEPS+1];

  logic [2:0][DIV_W-1:0]  dr_q  [Q_W+1];
  logic [2:0][Q_W-1:0]    dq_q  [Q_W+1];
  logic [ROOT_W-1:0]      dl_q  [Q_W+1];
  logic [ROOT_W-1:0]      len;

  always_comb begin
    mx_d = mag_i[0];
    if (mag_i[1] > mx_d) mx_d = mag_i[1];
    if (mag_i[2] > mx_d) mx_d = mag_i[2];
  end

  always_comb begin
    msb_d = '0;
    for (int k = 0; k < MAG_W; k++) begin
      if (mx_q[k]) msb_d = MSB_W'(k);
    end
    lsh_d = (msb_d <= MSB_W'(NORM_W - 1));
    amt_d = lsh_d ? SH_W'(MSB_W'(NORM_W - 1) - msb_d) : SH_W'(msb_d - MSB_W'(NORM_W - 1));
  end

  // largest magnitude lands in [2^29, 2^30); a right shift truncates
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n_d[i] = lsh_q ? NORM_W'(m2_q[i] << amt_q) : NORM_W'(m2_q[i] >> amt_q);
    end
  end

  always_ff @(posedge clk_i) begin
    m1_q     <= mag_i;
    mx_q     <= mx_d;
    m2_q     <= m1_q;
    lsh_q    <= lsh_d;
    amt_q    <= amt_d;
    n_q      <= n_d;
    nsq_q    <= n_q;
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= n_q[i] * n_q[i];
    end
    rem_q[0] <= SUM_W'(sq_q[0]) + SUM_W'(sq_q[1]) + SUM_W'(sq_q[2]);
    res_q[0] <= '0;
    nn_q[0]  <= nsq_q;
  end

  // one root bit per stage
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (SQRT_STEPS - 1 - j));
    logic [SUM_W:0] trial;
    assign trial = {1'b0, res_q[j]} + {1'b0, BIT};
    always_ff @(posedge clk_i) begin
      if ({1'b0, rem_q[j]} >= trial) begin
        rem_q[j+1] <= rem_q[j] - trial[SUM_W-1:0];
        res_q[j+1] <= (res_q[j] >> 1) + BIT;
      end else begin
        rem_q[j+1] <= rem_q[j];
        res_q[j+1] <= res_q[j] >> 1;
      end
      nn_q[j+1] <= nn_q[j];
    end
  end

  assign len = res_q[SQRT_STEPS][ROOT_W-1:0];

  // rounded numerator m*2^14 + L/2
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dr_q[0][i] <= DIV_W'({nn_q[SQRT_STEPS][i], {UNIT_SH{1'b0}}}) + DIV_W'(len >> 1);
    end
    dq_q[0] <= '0;
    dl_q[0] <= len;
  end

  // restoring divide, one quotient bit per stage
  for (genvar d = 0; d < Q_W; d++) begin : g_div
    localparam int unsigned K = Q_W - 1 - d;
    logic [DIV_W-1:0] trial;
    assign trial = DIV_W'(dl_q[d]) << K;
    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dr_q[d][i] >= trial) begin
          dr_q[d+1][i] <= dr_q[d][i] - trial;
          dq_q[d+1][i] <= dq_q[d][i] | (Q_W'(1) << K);
        end else begin
          dr_q[d+1][i] <= dr_q[d][i];
          dq_q[d+1][i] <= dq_q[d][i];
        end
      end
      dl_q[d+1] <= dl_q[d];
    end
  end

  assign quot_o = dq_q[Q_W];

endmodule

[design/triangle_tangent_binormal_top.sv]
// Top level of the per-triangle tangent/binormal unit.
//
// Input: one triangle per beat on item_i, taken at a clock edge where start
// is high and busy is low. busy is never raised: a triangle may enter every
// cycle, and throughput is one triangle per clock.
// Output: result_o carries unit tangent and binormal (Q1.14) and a status
// code; valid_o marks it for exactly one cycle. Results leave in order.
// From the accepting edge to the edge that takes the result, a triangle
// passes 5 front stages (input, deltas, products, cross terms,
// magnitudes), 52 in each normaliser (scaling, squares, a 31-stage square
// root and a 15-stage divider) and one output register.
// A failing triangle (zero determinant, zero tangent or zero binormal)
// returns zero vectors with the matching status.
// Reset clears every valid bit; items in flight are dropped. The receiver
// cannot stall, so nothing is ever held back.
module triangle_tangent_binormal_top import ttb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic valid_o,
  output out_t result_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  in_t  in_q;

  logic signed [DIFF_W-1:0] e1_q [3];
  logic signed [DIFF_W-1:0] e2_q [3];
  logic signed [DIFF_W-1:0] du1_q, dv1_q, du2_q, dv2_q;

  logic signed [PROD_W-1:0] pt1_q [3];
  logic signed [PROD_W-1:0] pt2_q [3];
  logic signed [PROD_W-1:0] pb1_q [3];
  logic signed [PROD_W-1:0] pb2_q [3];
  logic signed [PROD_W-1:0] pd1_q, pd2_q;

  logic signed [VEC_W-1:0] tan_q [3];
  logic signed [VEC_W-1:0] bin_q [3];
  logic signed [VEC_W-1:0] det_q;

  logic [2:0][MAG_W-1:0] tmag_q, bmag_q;
  side_t                 side_d, side_q;

  side_t sb_q  [UNIT_LAT];
  logic  sbv_q [UNIT_LAT];

  logic [2:0][Q_W-1:0] tquot, bquot;
  out_t                res_d;

  assign busy = 1'b0;

  function automatic logic signed [DIFF_W-1:0] delta(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    delta = {a[COMP_W-1], a} - {b[COMP_W-1], b};
  endfunction

  function automatic logic signed [15:0] apply_sign(logic neg, logic [Q_W-1:0] q);
    apply_sign = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q <= item_i;
    for (int i = 0; i < 3; i++) begin
      e1_q[i] <= delta(in_q.second_position[COMP_W*i +: COMP_W],
                       in_q.first_position[COMP_W*i +: COMP_W]);
      e2_q[i] <= delta(in_q.third_position[COMP_W*i +: COMP_W],
                       in_q.first_position[COMP_W*i +: COMP_W]);
    end
    du1_q <= delta(in_q.second_texcoord[15:0],  in_q.first_texcoord[15:0]);
    dv1_q <= delta(in_q.second_texcoord[31:16], in_q.first_texcoord[31:16]);
    du2_q <= delta(in_q.third_texcoord[15:0],   in_q.first_texcoord[15:0]);
    dv2_q <= delta(in_q.third_texcoord[31:16],  in_q.first_texcoord[31:16]);

    for (int i = 0; i < 3; i++) begin
      pt1_q[i] <= dv2_q * e1_q[i];
      pt2_q[i] <= dv1_q * e2_q[i];
      pb1_q[i] <= du1_q * e2_q[i];
      pb2_q[i] <= du2_q * e1_q[i];
    end
    pd1_q <= du1_q * dv2_q;
    pd2_q <= du2_q * dv1_q;

    for (int i = 0; i < 3; i++) begin
      tan_q[i] <= VEC_W'(pt1_q[i]) - VEC_W'(pt2_q[i]);
      bin_q[i] <= VEC_W'(pb1_q[i]) - VEC_W'(pb2_q[i]);
    end
    det_q <= VEC_W'(pd1_q) - VEC_W'(pd2_q);

    for (int i = 0; i < 3; i++) begin
      tmag_q[i] <= tan_q[i][VEC_W-1] ? MAG_W'(-tan_q[i]) : tan_q[i][MAG_W-1:0];
      bmag_q[i] <= bin_q[i][VEC_W-1] ? MAG_W'(-bin_q[i]) : bin_q[i][MAG_W-1:0];
    end
    side_q <= side_d;
  end

  // negative determinant flips both vectors
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      side_d.tsign[i] = tan_q[i][VEC_W-1] ^ det_q[VEC_W-1];
      side_d.bsign[i] = bin_q[i][VEC_W-1] ^ det_q[VEC_W-1];
    end
    priority if (det_q == '0) begin
      side_d.status = ST_DET_ZERO;
    end else if (tan_q[0] == '0 && tan_q[1] == '0 && tan_q[2] == '0) begin
      side_d.status = ST_TAN_ZERO;
    end else if (bin_q[0] == '0 && bin_q[1] == '0 && bin_q[2] == '0) begin
      side_d.status = ST_BIN_ZERO;
    end else begin
      side_d.status = ST_OK;
    end
  end

  ttb_unitize u_tan (
    .clk_i  (clk_i),
    .mag_i  (tmag_q),
    .quot_o (tquot)
  );

  ttb_unitize u_bin (
    .clk_i  (clk_i),
    .mag_i  (bmag_q),
    .quot_o (bquot)
  );

  // signs and status ride alongside the normalisers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < UNIT_LAT; k++) sbv_q[k] <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      sbv_q[0] <= v5_q;
      for (int k = 1; k < UNIT_LAT; k++) sbv_q[k] <= sbv_q[k-1];
      valid_o <= sbv_q[UNIT_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sb_q[0] <= side_q;
    for (int k = 1; k < UNIT_LAT; k++) sb_q[k] <= sb_q[k-1];
    result_o <= res_d;
  end

  always_comb begin
    res_d.status     = sb_q[UNIT_LAT-1].status;
    res_d.tangent_x  = '0;
    res_d.tangent_y  = '0;
    res_d.tangent_z  = '0;
    res_d.binormal_x = '0;
    res_d.binormal_y = '0;
    res_d.binormal_z = '0;
    if (sb_q[UNIT_LAT-1].status == ST_OK) begin
      res_d.tangent_x  = apply_sign(sb_q[UNIT_LAT-1].tsign[0], tquot[0]);
      res_d.tangent_y  = apply_sign(sb_q[UNIT_LAT-1].tsign[1], tquot[1]);
      res_d.tangent_z  = apply_sign(sb_q[UNIT_LAT-1].tsign[2], tquot[2]);
      res_d.binormal_x = apply_sign(sb_q[UNIT_LAT-1].bsign[0], bquot[0]);
      res_d.binormal_y = apply_sign(sb_q[UNIT_LAT-1].bsign[1], bquot[1]);
      res_d.binormal_z = apply_sign(sb_q[UNIT_LAT-1].bsign[2], bquot[2]);
    end
  end

  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(start, PIPE_LAT))
    else $error("result without a matching accepted triangle");

  a_fail_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.status != ST_OK) |->
      (result_o.tangent_x == '0 && result_o.tangent_y == '0 && result_o.tangent_z == '0 &&
       result_o.binormal_x == '0 && result_o.binormal_y == '0 && result_o.binormal_z == '0))
    else $error("failed triangle returned nonzero vectors");

  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && result_o.status == ST_OK) |->
      (result_o.tangent_x <= 16'sd16384 && result_o.tangent_x >= -16'sd16384 &&
       result_o.binormal_x <= 16'sd16384 && result_o.binormal_x >= -16'sd16384))
    else $error("normalised component out of range");

endmodule
